// File: sv/wsfu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfu_pkg
// shared types, codes and helpers of the websocket frame unmasker
// ---------------------------------------------------------------------------
package wsfu_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXTHI = 3'd2,
    PH_EXTLO = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5,
    PH_TRAIL = 3'd6
  } phase_t;

  // frame opcodes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // status codes
  localparam logic [2:0] ST_TEXT   = 3'd0;
  localparam logic [2:0] ST_BINARY = 3'd1;
  localparam logic [2:0] ST_PING   = 3'd2;
  localparam logic [2:0] ST_PONG   = 3'd3;
  localparam logic [2:0] ST_CLOSE  = 3'd4;
  localparam logic [2:0] ST_ERROR  = 3'd5;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [15:0] KEY_BYTES = 16'd4;

  // queue between parser and output side
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // one queue entry: an optional payload word, then an optional status word
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data;
    logic        has_status;
    logic [2:0]  status;
    logic [15:0] length;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [2:0] status_of_opcode(input logic [3:0] op);
    logic [2:0] st;
    case (op)
      OP_TEXT:   st = ST_TEXT;
      OP_BINARY: st = ST_BINARY;
      OP_PING:   st = ST_PING;
      OP_PONG:   st = ST_PONG;
      OP_CLOSE:  st = ST_CLOSE;
      default:   st = ST_ERROR;
    endcase
    return st;
  endfunction

endpackage

// File: sv/websocket_frame_unmasker_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// websocket_frame_unmasker_unit
// client-to-server websocket frame checker and payload unmasker
// ---------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall): one raw frame byte per word, with
//   frame_end set on the final byte of the frame
//   output channel (out_valid / out_stall): one result per word; kind 0 is
//   an unmasked payload byte, kind 1 is the closing status with last set
//   and the declared payload length
//   each taken payload or frame_end word is queued; its result is offered
//   once the entries ahead of it have gone. throughput: one input word per
//   cycle while the queue is not full. a frame_end byte that also carries
//   payload yields two output words, a four-entry queue absorbs that
//   when the receiver stalls the queue fills, then in_stall rises while the
//   queue is full; the parser keeps its state until words flow again
//   reset clears the parser, the queue pointers and the output split flag;
//   the block is ready for a frame header on the next cycle
//   on error status, payload words already sent belong to a bad frame
// ---------------------------------------------------------------------------
module websocket_frame_unmasker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  out_byte,
  output logic [2:0]  frame_status,
  output logic [15:0] payload_length,
  output logic        last
);
  import wsfu_pkg::*;

  entry_t  wr_entry;   // parser result for the current input word
  entry_t  head;       // oldest queued entry
  q_stat_t qstat;
  logic    push;
  logic    pop;

  // front: header checks, length and key capture, xor unmask
  wsfu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .frame_end (frame_end),
    .q_full    (qstat.full),
    .in_stall  (in_stall),
    .push      (push),
    .entry     (wr_entry)
  );

  // queue decouples parser from a stalling receiver
  wsfu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  // back: sends payload word first, then status word
  wsfu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .stat           (qstat),
    .out_stall      (out_stall),
    .pop            (pop),
    .out_valid      (out_valid),
    .kind           (kind),
    .out_byte       (out_byte),
    .frame_status   (frame_status),
    .payload_length (payload_length),
    .last           (last)
  );

  // never write into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("queue overflow");

  // queue cannot be empty and full together
  assert property (@(posedge clk) disable iff (rst) !(qstat.empty && qstat.full))
    else $error("queue count corrupt");

  // a payload word taken from an entry with status is followed by that status
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !kind && head.has_status) |=>
      (out_valid && kind && last))
    else $error("status word lost after payload");

  // popping only happens on a taken word
  assert property (@(posedge clk) disable iff (rst)
    pop |-> (out_valid && !out_stall && (kind || !head.has_status)))
    else $error("queue pop without delivery");

endmodule

// File: sv/wsfu_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfu_front
// header parser and unmasker: one input word per cycle, while not full, into the queue
// ---------------------------------------------------------------------------
module wsfu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            frame_end,
  input  logic            q_full,
  output logic            in_stall,
  output logic            push,
  output wsfu_pkg::entry_t entry
);
  import wsfu_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        error_seen, error_seen_next;
  logic [15:0] decl_len, decl_len_next;
  logic [15:0] byte_cnt, byte_cnt_next;
  logic [31:0] mask_key, mask_key_next;
  logic [15:0] cnt_inc;
  logic [7:0]  key_byte;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cnt_inc  = byte_cnt + 16'd1;

  always_comb begin
    case (byte_cnt[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // next-state logic
  always_comb begin
    phase_next      = phase;
    opcode_next     = opcode;
    error_seen_next = error_seen;
    decl_len_next   = decl_len;
    byte_cnt_next   = byte_cnt;
    mask_key_next   = mask_key;
    case (phase)
      PH_HDR0: begin
        opcode_next = in_byte[3:0];
        if (!in_byte[7] || (in_byte[6:4] != 3'd0) ||
            (status_of_opcode(in_byte[3:0]) == ST_ERROR)) begin
          error_seen_next = 1'b1;
          phase_next      = PH_TRAIL;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (!in_byte[7] || (in_byte[6:0] == LEN_CODE_64)) begin
          error_seen_next = 1'b1;
          phase_next      = PH_TRAIL;
        end else if (in_byte[6:0] == LEN_CODE_16) begin
          phase_next = PH_EXTHI;
        end else begin
          decl_len_next = {9'd0, in_byte[6:0]};
          byte_cnt_next = 16'd0;
          phase_next    = PH_KEY;
        end
      end
      PH_EXTHI: begin
        decl_len_next = {in_byte, 8'h00};
        phase_next    = PH_EXTLO;
      end
      PH_EXTLO: begin
        decl_len_next = decl_len | {8'h00, in_byte};
        byte_cnt_next = 16'd0;
        phase_next    = PH_KEY;
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], in_byte};
        if (cnt_inc >= KEY_BYTES) begin
          byte_cnt_next = 16'd0;
          phase_next    = (decl_len == 16'd0) ? PH_TRAIL : PH_DATA;
        end else begin
          byte_cnt_next = cnt_inc;
        end
      end
      PH_DATA: begin
        byte_cnt_next = cnt_inc;
        if (cnt_inc >= decl_len) begin
          phase_next = PH_TRAIL;
        end
      end
      default: begin
      end
    endcase
  end

  // queue entry for the current input word
  always_comb begin
    entry = '0;
    if (phase == PH_DATA) begin
      entry.has_data = 1'b1;
      entry.data     = in_byte ^ key_byte;
    end
    if (frame_end) begin
      entry.has_status = 1'b1;
      entry.status     = (error_seen_next || (phase_next != PH_TRAIL)) ?
                         ST_ERROR : status_of_opcode(opcode_next);
      entry.length     = decl_len_next;
    end
  end

  assign push = accept && (entry.has_data || entry.has_status);

  always_ff @(posedge clk) begin
    if (rst || (accept && frame_end)) begin
      phase      <= PH_HDR0;
      opcode     <= 4'd0;
      error_seen <= 1'b0;
      decl_len   <= 16'd0;
      byte_cnt   <= 16'd0;
      mask_key   <= 32'd0;
    end else if (accept) begin
      phase      <= phase_next;
      opcode     <= opcode_next;
      error_seen <= error_seen_next;
      decl_len   <= decl_len_next;
      byte_cnt   <= byte_cnt_next;
      mask_key   <= mask_key_next;
    end
  end

endmodule

// File: sv/wsfu_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfu_queue
// short entry queue between parser and output side
// ---------------------------------------------------------------------------
module wsfu_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsfu_pkg::entry_t  wr_entry,
  input  logic              pop,
  output wsfu_pkg::entry_t  head,
  output wsfu_pkg::q_stat_t stat
);
  import wsfu_pkg::*;

  entry_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QAW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/wsfu_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfu_back
// output side: splits a queue entry into payload and status words
// ---------------------------------------------------------------------------
module wsfu_back (
  input  logic              clk,
  input  logic              rst,
  input  wsfu_pkg::entry_t  head,
  input  wsfu_pkg::q_stat_t stat,
  input  logic              out_stall,
  output logic              pop,
  output logic              out_valid,
  output logic              kind,
  output logic [7:0]        out_byte,
  output logic [2:0]        frame_status,
  output logic [15:0]       payload_length,
  output logic              last
);
  import wsfu_pkg::*;

  logic data_done;
  logic show_data;
  logic take;
  logic split;

  assign out_valid = !stat.empty;
  assign show_data = head.has_data && !data_done;
  assign take      = out_valid && !out_stall;
  // payload word now, status word still to come
  assign split     = show_data && head.has_status;
  assign pop       = take && !split;

  always_comb begin
    if (show_data) begin
      kind           = 1'b0;
      out_byte       = head.data;
      frame_status   = ST_TEXT;
      payload_length = 16'd0;
      last           = 1'b0;
    end else begin
      kind           = 1'b1;
      out_byte       = 8'd0;
      frame_status   = head.status;
      payload_length = head.length;
      last           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_done <= 1'b0;
    end else if (take) begin
      data_done <= split;
    end
  end

endmodule
